[rtl/sloe_pkg.sv]
// ----------------------------------------------------------------------------
// sloe_pkg
// Shared constants, types and type tables for the struct layout offset engine.
// ----------------------------------------------------------------------------
package sloe_pkg;

  localparam int MAX_MEMBERS = 16;
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
  localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

  localparam logic [1:0] ACT_DEFINE = 2'd0;
  localparam logic [1:0] ACT_LOCATE = 2'd1;
  localparam logic [1:0] ACT_SIZE   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_BAD_SLOT = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [3:0] TY_INT   = 4'd0;
  localparam logic [3:0] TY_UINT  = 4'd1;
  localparam logic [3:0] TY_IVEC2 = 4'd2;
  localparam logic [3:0] TY_UVEC2 = 4'd3;
  localparam logic [3:0] TY_IVEC3 = 4'd4;
  localparam logic [3:0] TY_UVEC3 = 4'd5;
  localparam logic [3:0] TY_IVEC4 = 4'd6;
  localparam logic [3:0] TY_UVEC4 = 4'd7;
  localparam logic [3:0] TY_FLOAT = 4'd8;
  localparam logic [3:0] TY_VEC2  = 4'd9;
  localparam logic [3:0] TY_VEC3  = 4'd10;
  localparam logic [3:0] TY_VEC4  = 4'd11;
  localparam logic [3:0] TY_MAT4  = 4'd12;

  localparam int MAX_SIZE = 65535;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALIGN,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic load;    // capture input word
    logic calc;    // lookup, align, multiply
    logic finish;  // commit state, load result word
  } cmd_t;

  // base alignment in bytes, zero for unknown codes
  function automatic logic [4:0] type_align(input logic [3:0] ty);
    logic [4:0] a;
    a = 5'd0;
    case (ty) inside
      TY_INT, TY_UINT, TY_FLOAT, TY_MAT4:                    a = 5'd4;
      TY_IVEC2, TY_UVEC2, TY_VEC2:                           a = 5'd8;
      TY_IVEC3, TY_UVEC3, TY_IVEC4, TY_UVEC4, TY_VEC3, TY_VEC4: a = 5'd16;
      default:                                               a = 5'd0;
    endcase
    return a;
  endfunction

  // byte size, zero for unknown codes
  function automatic logic [6:0] type_size(input logic [3:0] ty);
    logic [6:0] s;
    s = 7'd0;
    case (ty) inside
      TY_INT, TY_UINT, TY_FLOAT:              s = 7'd4;
      TY_IVEC2, TY_UVEC2, TY_VEC2:            s = 7'd8;
      TY_IVEC3, TY_UVEC3, TY_VEC3:            s = 7'd12;
      TY_IVEC4, TY_UVEC4, TY_VEC4:            s = 7'd16;
      TY_MAT4:                                s = 7'd64;
      default:                                s = 7'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/sloe_ctrl.sv]
// ----------------------------------------------------------------------------
// sloe_ctrl
// Sequencer: accept a word, run the lookup step and the commit step, and
// hold the result word until the consumer takes it.
// ----------------------------------------------------------------------------
module sloe_ctrl
  import sloe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   can_finish;

  assign can_finish = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_ALIGN;
      S_ALIGN: state_next = S_CHECK;
      S_CHECK: if (can_finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.calc   = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_ALIGN: cmd.calc = 1'b1;
      S_CHECK: cmd.finish = can_finish;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_valid_next = cmd.finish || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/sloe_dp.sv]
// ----------------------------------------------------------------------------
// sloe_dp
// Layout datapath: member tables, running size, alignment, stride, the
// stride multiplier and the result word registers.
// ----------------------------------------------------------------------------
module sloe_dp
  import sloe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [1:0]  action,
  input  logic [3:0]  member_type,
  input  logic [3:0]  member_slot,
  input  logic [15:0] element_index,
  input  logic [15:0] element_count,
  output logic [2:0]  status,
  output logic [3:0]  assigned_slot,
  output logic [31:0] byte_address,
  output logic [6:0]  byte_count,
  output logic [15:0] struct_stride
);

  // captured input word
  logic [1:0]  act;
  logic [3:0]  mtype;
  logic [3:0]  slot;
  logic [15:0] elem;
  logic [15:0] cnt;

  // layout state
  logic [CNT_W-1:0] member_count, member_count_next;
  logic [15:0]      running_size, running_size_next;
  logic [4:0]       largest_alignment, largest_alignment_next;
  logic [15:0]      stride, stride_next;
  logic [15:0]      member_offsets [MAX_MEMBERS];
  logic [6:0]       member_sizes [MAX_MEMBERS];

  // lookup stage
  logic [16:0] a_off;
  logic [16:0] a_ns;
  logic [4:0]  a_nl;
  logic [6:0]  a_size;
  logic        a_full;
  logic        a_badty;
  logic        a_badslot;
  logic [31:0] a_prod;
  logic [15:0] rd_off;
  logic [6:0]  rd_size;

  logic [4:0]  ty_a;
  logic [6:0]  ty_s;
  logic [16:0] mask_a;
  logic [16:0] off_c;
  logic [16:0] mask_l;
  logic [17:0] ns_al;
  logic        overflow;
  logic        commit;
  logic [15:0] mul_b;

  logic [2:0]  status_c;
  logic [31:0] addr_c;
  logic [6:0]  bcnt_c;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= action;
      mtype <= member_type;
      slot  <= member_slot;
      elem  <= element_index;
      cnt   <= element_count;
    end
  end

  // lookup, align the offset, stride multiply
  always_comb begin
    ty_a   = type_align(mtype);
    ty_s   = type_size(mtype);
    mask_a = 17'(ty_a) - 17'd1;
    off_c  = (17'(running_size) + mask_a) & ~mask_a;
    mul_b  = (act == ACT_LOCATE) ? elem : cnt;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      a_off     <= off_c;
      a_ns      <= off_c + 17'(ty_s);
      a_nl      <= (largest_alignment < ty_a) ? ty_a : largest_alignment;
      a_size    <= ty_s;
      a_full    <= (32'(member_count) >= 32'(MAX_MEMBERS));
      a_badty   <= (mtype > TY_MAT4);
      a_badslot <= (32'(slot) >= 32'(member_count)) || (32'(slot) >= 32'(MAX_MEMBERS));
      a_prod    <= 32'(stride) * 32'(mul_b);
      rd_off    <= member_offsets[IDX_W'(slot)];
      rd_size   <= member_sizes[IDX_W'(slot)];
    end
  end

  // overflow check, commit, result
  always_comb begin
    mask_l   = 17'(a_nl) - 17'd1;
    ns_al    = 18'((a_ns + mask_l) & ~mask_l) ;
    overflow = (a_ns > 17'(MAX_SIZE)) || (ns_al > 18'(MAX_SIZE));

    status_c = ST_OK;
    addr_c   = 32'd0;
    bcnt_c   = 7'd0;
    commit   = 1'b0;
    member_count_next      = member_count;
    running_size_next      = running_size;
    largest_alignment_next = largest_alignment;
    stride_next            = stride;
    case (act)
      ACT_DEFINE: begin
        if (a_full) begin
          status_c = ST_FULL;
        end else if (a_badty) begin
          status_c = ST_BAD_TYPE;
        end else if (overflow) begin
          status_c = ST_OVERFLOW;
        end else begin
          commit = 1'b1;
          addr_c = 32'(a_off);
          bcnt_c = a_size;
          member_count_next      = member_count + CNT_W'(1);
          running_size_next      = a_ns[15:0];
          largest_alignment_next = a_nl;
          stride_next            = ns_al[15:0];
        end
      end
      ACT_LOCATE: begin
        if (a_badslot) begin
          status_c = ST_BAD_SLOT;
        end else begin
          addr_c = a_prod + 32'(rd_off);
          bcnt_c = rd_size;
        end
      end
      ACT_SIZE: addr_c = a_prod;
      default: begin
        member_count_next      = '0;
        running_size_next      = 16'd0;
        largest_alignment_next = 5'd0;
        stride_next            = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      member_count      <= '0;
      running_size      <= 16'd0;
      largest_alignment <= 5'd0;
      stride            <= 16'd0;
    end else if (cmd.finish) begin
      member_count      <= member_count_next;
      running_size      <= running_size_next;
      largest_alignment <= largest_alignment_next;
      stride            <= stride_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && commit) begin
      member_offsets[IDX_W'(member_count)] <= a_off[15:0];
      member_sizes[IDX_W'(member_count)]   <= a_size;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status        <= status_c;
      assigned_slot <= commit ? 4'(member_count) : 4'd0;
      byte_address  <= addr_c;
      byte_count    <= bcnt_c;
      struct_stride <= stride_next;
    end
  end

endmodule

[rtl/struct_layout_offset_engine.sv]
// ----------------------------------------------------------------------------
// struct_layout_offset_engine
// Builds a buffer struct layout one member at a time; locates array elements
// and reports buffer sizes.
// ----------------------------------------------------------------------------
// Usage: each input word is taken in the idle state and its result word is
// loaded after the table lookup plus stride multiply step and then the
// overflow check plus commit step, so the block takes no new word until the
// last one has been committed; a held result only delays the commit step.
// The result register frees the input side: the next word may be accepted
// while the last result still waits. Member slots are handed out in order
// from zero; locating a slot that was never defined returns bad slot.
module struct_layout_offset_engine
  import sloe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [3:0]  member_type,
  input  logic [3:0]  member_slot,
  input  logic [15:0] element_index,
  input  logic [15:0] element_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  assigned_slot,
  output logic [31:0] byte_address,
  output logic [6:0]  byte_count,
  output logic [15:0] struct_stride
);

  cmd_t cmd;

  sloe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sloe_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (action),
    .member_type   (member_type),
    .member_slot   (member_slot),
    .element_index (element_index),
    .element_count (element_count),
    .status        (status),
    .assigned_slot (assigned_slot),
    .byte_address  (byte_address),
    .byte_count    (byte_count),
    .struct_stride (struct_stride)
  );

endmodule

[rtl/sloe_chk.sv]
// ----------------------------------------------------------------------------
// sloe_chk
// Port-level checks for the struct layout offset engine.
// ----------------------------------------------------------------------------
module sloe_chk
  import sloe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] byte_address,
  input logic [6:0]  byte_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // result register is loaded in the commit step after the accepted word
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##3 out_valid)
    else $error("no result after accepted word");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_OVERFLOW)
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> byte_address == 32'd0 && byte_count == 7'd0)
    else $error("error result carries data");

endmodule

bind struct_layout_offset_engine sloe_chk u_sloe_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .byte_address (byte_address),
  .byte_count   (byte_count)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for struct_layout_offset_engine: drives member defines,
// element locates, size queries and clears with random gaps on both sides and
// checks every result word against a layout scoreboard kept alongside.
// ----------------------------------------------------------------------------
import sloe_pkg::*;

typedef struct packed {
  logic [2:0]  status;
  logic [3:0]  assigned_slot;
  logic [31:0] byte_address;
  logic [6:0]  byte_count;
  logic [15:0] struct_stride;
} layout_reply_t;

class layout_board;
  bit [15:0]     member_offs [MAX_MEMBERS];
  bit [6:0]      member_bytes [MAX_MEMBERS];
  int unsigned   members;
  int unsigned   used_bytes;
  int unsigned   widest_align;
  layout_reply_t pending_replies [$];
  int            failures;
  int            reports;

  function new();
    members      = 0;
    used_bytes   = 0;
    widest_align = 0;
    failures     = 0;
    reports      = 0;
  endfunction

  function int unsigned base_align(logic [3:0] ty);
    case (ty)
      TY_INT, TY_UINT, TY_FLOAT, TY_MAT4: return 4;
      TY_IVEC2, TY_UVEC2, TY_VEC2:        return 8;
      default:                            return 16;
    endcase
  endfunction

  function int unsigned byte_size(logic [3:0] ty);
    case (ty)
      TY_INT, TY_UINT, TY_FLOAT:   return 4;
      TY_IVEC2, TY_UVEC2, TY_VEC2: return 8;
      TY_IVEC3, TY_UVEC3, TY_VEC3: return 12;
      TY_MAT4:                     return 64;
      default:                     return 16;
    endcase
  endfunction

  function int unsigned round_up(int unsigned v, int unsigned a);
    if (a == 0) return v;
    return ((v + a - 1) / a) * a;
  endfunction

  function int unsigned stride();
    return round_up(used_bytes, widest_align);
  endfunction

  // predict the reply for one accepted word and update the layout
  function void note_request(logic [1:0] act, logic [3:0] ty, logic [3:0] slot,
                             logic [15:0] idx, logic [15:0] cnt);
    layout_reply_t    w;
    int unsigned      a, s, off, ns, nl;
    longint unsigned  addr;
    w = '0;
    case (act)
      ACT_DEFINE: begin
        if (members >= MAX_MEMBERS) begin
          w.status = ST_FULL;
        end else if (ty > TY_MAT4) begin
          w.status = ST_BAD_TYPE;
        end else begin
          a   = base_align(ty);
          s   = byte_size(ty);
          off = round_up(used_bytes, a);
          ns  = off + s;
          nl  = (widest_align < a) ? a : widest_align;
          if (ns > MAX_SIZE || round_up(ns, nl) > MAX_SIZE) begin
            w.status = ST_OVERFLOW;
          end else begin
            member_offs[members]  = off[15:0];
            member_bytes[members] = s[6:0];
            w.assigned_slot = members[3:0];
            w.byte_address  = off;
            w.byte_count    = s[6:0];
            members++;
            used_bytes   = ns;
            widest_align = nl;
          end
        end
      end
      ACT_LOCATE: begin
        if (slot >= members) begin
          w.status = ST_BAD_SLOT;
        end else begin
          addr = longint'(stride()) * idx + member_offs[slot];
          w.byte_address = addr[31:0];
          w.byte_count   = member_bytes[slot];
        end
      end
      ACT_SIZE: begin
        addr = longint'(stride()) * cnt;
        w.byte_address = addr[31:0];
      end
      default: begin
        members      = 0;
        used_bytes   = 0;
        widest_align = 0;
      end
    endcase
    w.struct_stride = stride();
    pending_replies.push_back(w);
  endfunction

  function void check_reply(layout_reply_t got);
    layout_reply_t w;
    if (pending_replies.size() == 0) begin
      failures++;
      if (reports < 10) $display("unexpected result word %h", got);
      reports++;
      return;
    end
    w = pending_replies.pop_front();
    if (got.status !== w.status || got.assigned_slot !== w.assigned_slot ||
        got.byte_address !== w.byte_address || got.byte_count !== w.byte_count ||
        got.struct_stride !== w.struct_stride) begin
      failures++;
      if (reports < 10)
        $display("mismatch: exp st=%0d slot=%0d addr=%0d cnt=%0d stride=%0d",
                 w.status, w.assigned_slot, w.byte_address, w.byte_count,
                 w.struct_stride, "  got st=%0d slot=%0d addr=%0d cnt=%0d stride=%0d",
                 got.status, got.assigned_slot, got.byte_address, got.byte_count,
                 got.struct_stride);
      reports++;
    end
  endfunction
endclass

module tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_CLEAR;
  logic [3:0]  member_type = TY_INT;
  logic [3:0]  member_slot = 4'd0;
  logic [15:0] element_index = 16'd0;
  logic [15:0] element_count = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [3:0]  assigned_slot;
  logic [31:0] byte_address;
  logic [6:0]  byte_count;
  logic [15:0] struct_stride;

  layout_board board = new();
  bit          steady = 1'b0;
  int          hold_left = 0;

  struct_layout_offset_engine uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .member_type(member_type), .member_slot(member_slot),
    .element_index(element_index), .element_count(element_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .assigned_slot(assigned_slot), .byte_address(byte_address),
    .byte_count(byte_count), .struct_stride(struct_stride)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // input side first so a reply in the same cycle as its word would still find its expectation
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      board.note_request(action, member_type, member_slot, element_index, element_count);
    if (!rst && out_valid && out_ready)
      board.check_reply({status, assigned_slot, byte_address, byte_count, struct_stride});
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 20) begin
      out_ready <= 1'b0;
      hold_left <= idle_span() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(logic [1:0] act, logic [3:0] ty, logic [3:0] slot,
                           logic [15:0] idx, logic [15:0] cnt);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 45) ? idle_span() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    member_type   <= ty;
    member_slot   <= slot;
    element_index <= idx;
    element_count <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_replies.size() != 0) @(posedge clk);
  endtask

  // well-formed traffic with random content; a full table is now and then cleared
  task automatic random_word();
    int          r;
    logic [1:0]  act;
    logic [3:0]  ty, slot;
    r    = $urandom_range(0, 99);
    ty   = 4'($urandom_range(0, 15));
    slot = 4'($urandom_range(0, 15));
    if (board.members >= MAX_MEMBERS && $urandom_range(0, 99) < 30) begin
      act = ACT_CLEAR;
    end else if (r < 40) begin
      act = ACT_DEFINE;
      if ($urandom_range(0, 99) < 90) ty = 4'($urandom_range(TY_INT, TY_MAT4));
    end else if (r < 75) begin
      act = ACT_LOCATE;
      if (board.members > 0 && $urandom_range(0, 99) < 85)
        slot = 4'($urandom_range(0, board.members - 1));
    end else if (r < 97) begin
      act = ACT_SIZE;
    end else begin
      act = ACT_CLEAR;
    end
    send_word(act, ty, slot, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty layout: locate fails, size is zero
    send_word(ACT_LOCATE, TY_INT, 4'd0, 16'd0, 16'd0);
    send_word(ACT_SIZE, TY_INT, 4'd0, 16'hffff, 16'hffff);
    // every known type once, padding between them
    for (int t = TY_INT; t <= TY_MAT4; t++)
      send_word(ACT_DEFINE, t[3:0], 4'd0, 16'd0, 16'd0);
    send_word(ACT_DEFINE, 4'd13, 4'd0, 16'd0, 16'd0);
    send_word(ACT_DEFINE, 4'd15, 4'd0, 16'd0, 16'd0);
    send_word(ACT_LOCATE, TY_INT, 4'd12, 16'hffff, 16'd0);
    send_word(ACT_LOCATE, TY_INT, 4'd13, 16'd0, 16'd0);
    send_word(ACT_SIZE, TY_INT, 4'd0, 16'd0, 16'hffff);
    send_word(ACT_DEFINE, TY_VEC4, 4'd0, 16'd0, 16'd0);
    send_word(ACT_DEFINE, TY_MAT4, 4'd0, 16'd0, 16'd0);
    send_word(ACT_DEFINE, TY_IVEC3, 4'd0, 16'd0, 16'd0);
    // table full wins over an unknown type
    send_word(ACT_DEFINE, TY_INT, 4'd0, 16'd0, 16'd0);
    send_word(ACT_DEFINE, 4'd14, 4'd0, 16'd0, 16'd0);
    send_word(ACT_LOCATE, TY_INT, 4'd15, 16'hffff, 16'hffff);
    send_word(ACT_CLEAR, 4'd15, 4'd15, 16'hffff, 16'hffff);
    wait_drained();

    for (int i = 0; i < 1200; i++) begin
      steady = (i % 200) < 40;
      if (i % 300 == 150) wait_drained();
      random_word();
    end

    steady = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk);
    if (board.pending_replies.size() != 0) begin
      board.failures += board.pending_replies.size();
      $display("%0d result words never arrived", board.pending_replies.size());
    end
    if (board.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
